>>> hw/rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// shared types, constants and crc helper for the sample decoder
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int WORD_W  = 14;
    localparam int PROD_W  = 31;
    localparam int NUM_W   = 32;
    localparam int VALUE_W = 15;

    localparam logic       ACTION_TEMP     = 1'b0;
    localparam logic       ACTION_HUMIDITY = 1'b1;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_TOP_BIT = 8'h80;
    localparam logic [7:0]  CRC_INIT    = 8'h00;
    localparam logic [15:0] STATUS_MASK = 16'h0003;

    localparam logic [PROD_W-1:0] T_SLOPE  = PROD_W'(17572);
    localparam logic [PROD_W-1:0] RH_SLOPE = PROD_W'(12500);

    localparam logic signed [NUM_W-1:0] T_OFFSET_SCALED  = NUM_W'(-4685 * 65536);
    localparam logic signed [NUM_W-1:0] RH_OFFSET_SCALED = NUM_W'(-600 * 65536);
    localparam logic signed [NUM_W-1:0] ROUND_TO_ZERO    = NUM_W'(65535);
    localparam int                      SCALE_SHIFT      = 16;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] word;
        logic [7:0]        raw_low;
        logic [7:0]        received_crc;
        logic [7:0]        crc_high;
    } hts_s1_t;

    typedef struct packed {
        logic              action;
        logic [PROD_W-1:0] prod;
        logic              crc_error;
    } hts_s2_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP_BIT) != 8'h00)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/hts_if.sv
// ----------------------------------------------------------------------------
// hts_if
// valid/ready channels for raw frames and decoded values
// ----------------------------------------------------------------------------
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] raw_high;
    logic [7:0] raw_low;
    logic [7:0] received_crc;

    modport source (output valid, action, raw_high, raw_low, received_crc, input ready);
    modport sink (input valid, action, raw_high, raw_low, received_crc, output ready);
endinterface

interface hts_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] value_hundredths;
    logic               crc_error;

    modport source (output valid, value_hundredths, crc_error, input ready);
    modport sink (input valid, value_hundredths, crc_error, output ready);
endinterface

>>> hw/rtl/humidity_temp_sample_decode.sv
// ----------------------------------------------------------------------------
// humidity_temp_sample_decode
// crc-8 check and fixed-point conversion of raw temperature/humidity frames
//
//   channel  dir  payload
//   sample   in   action, raw_high, raw_low, received_crc
//   result   out  value_hundredths (signed), crc_error
//
// three register stages: crc high byte, slope multiply with crc low byte,
// offset add and scale; one transaction per cycle while result is not stalled.
// the multiply stage sets the clock budget.
// rst_n clears the stage valid bits only.
// a stall on result backs up through the ready chain without losing data.
// ----------------------------------------------------------------------------
module humidity_temp_sample_decode
    import hts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hts_in_if.sink   sample,
    hts_out_if.source result
);

    logic    s1_valid;
    logic    s1_ready;
    hts_s1_t s1_data;
    logic    s2_valid;
    logic    s2_ready;
    hts_s2_t s2_data;

    hts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample.valid),
        .in_ready     (sample.ready),
        .action       (sample.action),
        .raw_high     (sample.raw_high),
        .raw_low      (sample.raw_low),
        .received_crc (sample.received_crc),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_data     (s1_data)
    );

    hts_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    hts_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s2_valid),
        .in_ready         (s2_ready),
        .in_data          (s2_data),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .value_hundredths (result.value_hundredths),
        .crc_error        (result.crc_error)
    );

endmodule

>>> hw/rtl/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front
// first stage: masks status bits and runs the crc over the high byte
// ----------------------------------------------------------------------------
module hts_front
    import hts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] raw_high,
    input  logic [7:0] raw_low,
    input  logic [7:0] received_crc,
    output logic       out_valid,
    input  logic       out_ready,
    output hts_s1_t    out_data
);

    logic    valid_reg;
    hts_s1_t data_reg;
    hts_s1_t data_next;
    logic [15:0] raw_word;

    assign raw_word = {raw_high, raw_low} & ~STATUS_MASK;

    always_comb
    begin
        data_next.action       = action;
        data_next.word         = raw_word[15:2];
        data_next.raw_low      = raw_low;
        data_next.received_crc = received_crc;
        data_next.crc_high     = crc8_feed(CRC_INIT, raw_high);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/hts_mult.sv
// ----------------------------------------------------------------------------
// hts_mult
// second stage: slope multiply and crc over the low byte
// ----------------------------------------------------------------------------
module hts_mult
    import hts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  hts_s1_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output hts_s2_t out_data
);

    logic              valid_reg;
    hts_s2_t           data_reg;
    hts_s2_t           data_next;
    logic [PROD_W-1:0] slope;
    logic [7:0]        crc_full;

    assign slope    = (in_data.action == ACTION_HUMIDITY) ? RH_SLOPE : T_SLOPE;
    assign crc_full = crc8_feed(in_data.crc_high, in_data.raw_low);

    always_comb
    begin
        data_next.action    = in_data.action;
        data_next.prod      = slope * PROD_W'({in_data.word, 2'b00});
        data_next.crc_error = (crc_full != in_data.received_crc);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/hts_scale.sv
// ----------------------------------------------------------------------------
// hts_scale
// third stage: adds the offset and divides by 65536 toward zero
// ----------------------------------------------------------------------------
module hts_scale
    import hts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hts_s2_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] value_hundredths,
    output logic                      crc_error
);

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      crc_error_reg;
    logic signed [NUM_W-1:0]   offset;
    logic signed [NUM_W-1:0]   num;
    logic signed [NUM_W-1:0]   num_adj;
    logic signed [NUM_W-1:0]   quot;

    assign offset = (in_data.action == ACTION_HUMIDITY) ? RH_OFFSET_SCALED : T_OFFSET_SCALED;
    assign num    = offset + $signed({1'b0, in_data.prod});

    // truncate toward zero for negative numerators
    assign num_adj    = num[NUM_W-1] ? (num + ROUND_TO_ZERO) : num;
    assign quot       = num_adj >>> SCALE_SHIFT;
    assign value_next = quot[VALUE_W-1:0];

    assign in_ready         = !valid_reg || out_ready;
    assign out_valid        = valid_reg;
    assign value_hundredths = value_reg;
    assign crc_error        = crc_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg     <= value_next;
            crc_error_reg <= in_data.crc_error;
        end
    end

endmodule

>>> hw/rtl/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// port-level checks on the sample decoder
// ----------------------------------------------------------------------------
module hts_checker
    import hts_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      sample_valid,
    input logic                      sample_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic signed [VALUE_W-1:0] value_hundredths,
    input logic                      crc_error
);

    logic sample_acc;

    assign sample_acc = sample_valid && sample_ready;

    // a result waiting on the sink stays up
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(value_hundredths) && $stable(crc_error))
        else $error("result payload changed while stalled");

    // a draining sink never blocks the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("sample stalled while result is taken");

    // with no new transactions accepted and the result taken, the pipeline empties
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!sample_acc && result_ready) ##1 (!sample_acc && result_ready)
        ##1 (!sample_acc && result_ready) |=> !result_valid)
        else $error("pipeline did not drain");

endmodule

bind humidity_temp_sample_decode hts_checker u_hts_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_valid     (sample.valid),
    .sample_ready     (sample.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .value_hundredths (result.value_hundredths),
    .crc_error        (result.crc_error)
);
